[hdl/vt100_utf8_sequence_parser_unit_macros.svh]
// Assertion macros for the terminal sequence parser checker.
// Needs clk and rst in the scope where the macros are used.
`ifndef VT100_UTF8_SEQUENCE_PARSER_UNIT_MACROS_SVH
`define VT100_UTF8_SEQUENCE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define VUSP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define VUSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/vusp_pkg.sv]
// Shared types and constants of the terminal sequence parser.
// No dependencies; used by every module of the block.
package vusp_pkg;

  localparam int PARAM_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 4;
  localparam int VALUE_W    = 16;

  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_CSI   = 8'h5b;
  localparam logic [7:0] BYTE_QMARK = 8'h3f;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;
  localparam logic [7:0] BYTE_DIG0  = 8'h30;
  localparam logic [7:0] BYTE_DIG9  = 8'h39;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hffff;

  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_ESC   = 3'd1;
  localparam logic [2:0] KIND_CSI   = 3'd2;
  localparam logic [2:0] KIND_CSIQ  = 3'd3;
  localparam logic [2:0] KIND_UTF8  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        is_error;
    logic [7:0]  final_byte;
    logic [31:0] glyph;
  } run_head_t;

endpackage

[hdl/vusp_front.sv]
// Front part: byte parser that builds one run descriptor per completed element.
// Depends on vusp_pkg.
module vusp_front #(
  parameter int SLOTS = vusp_pkg::PARAM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [7:0]                         in_byte,
  output logic                               push,
  output vusp_pkg::run_head_t                run_head,
  output logic [$clog2(SLOTS+1)-1:0]         run_count,
  output logic [SLOTS*vusp_pkg::VALUE_W-1:0] run_params
);
  import vusp_pkg::*;

  localparam int PW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    MODE_RAW  = 5'b00001,
    MODE_ESC  = 5'b00010,
    MODE_CSI  = 5'b00100,
    MODE_CSIQ = 5'b01000,
    MODE_UTF8 = 5'b10000
  } mode_t;

  mode_t              mode, mode_next;
  logic [31:0]        glyph_acc, glyph_acc_next;
  logic [2:0]         cont_left, cont_left_next;
  logic [PW-1:0]      param_ptr, param_ptr_next;
  logic [VALUE_W-1:0] param_store [SLOTS];
  logic [VALUE_W-1:0] param_store_next [SLOTS];

  logic               emit;
  logic [19:0]        digit_prod;
  logic [31:0]        glyph_shift;
  logic [2:0]         cont_dec;
  logic [2:0]         want;
  logic [7:0]         lead_mask;
  logic               ptr_room;
  logic               cur_nonzero;
  logic               is_digit;

  assign digit_prod  = 20'(param_store[param_ptr]) * 20'd10 + 20'(in_byte[3:0]);
  assign glyph_shift = {glyph_acc[25:0], in_byte[5:0]};
  assign cont_dec    = (cont_left != 3'd0) ? cont_left - 3'd1 : 3'd0;
  assign ptr_room    = (CW'(param_ptr) + CW'(1)) < CW'(SLOTS);
  assign cur_nonzero = param_store[param_ptr] != '0;
  assign is_digit    = (in_byte >= BYTE_DIG0) && (in_byte <= BYTE_DIG9);
  assign lead_mask   = 8'hff >> (want + 3'd1);

  // Count the leading ones below bit 7 of a lead byte, at most five.
  always_comb begin
    if (!in_byte[6]) begin
      want = 3'd0;
    end else if (!in_byte[5]) begin
      want = 3'd1;
    end else if (!in_byte[4]) begin
      want = 3'd2;
    end else if (!in_byte[3]) begin
      want = 3'd3;
    end else if (!in_byte[2]) begin
      want = 3'd4;
    end else begin
      want = 3'd5;
    end
  end

  always_comb begin
    mode_next        = mode;
    glyph_acc_next   = glyph_acc;
    cont_left_next   = cont_left;
    param_ptr_next   = param_ptr;
    param_store_next = param_store;
    emit             = 1'b0;
    run_head         = '{kind: KIND_PLAIN, is_error: 1'b0, final_byte: in_byte, glyph: 32'd0};
    run_count        = '0;
    case (mode)
      MODE_RAW: begin
        if (in_byte == BYTE_ESC) begin
          mode_next = MODE_ESC;
        end else if (in_byte[7]) begin
          cont_left_next = want;
          glyph_acc_next = {24'd0, in_byte & lead_mask};
          mode_next      = MODE_UTF8;
        end else begin
          emit           = 1'b1;
          run_head.glyph = {24'd0, in_byte};
        end
      end
      MODE_ESC: begin
        if (in_byte == BYTE_CSI) begin
          mode_next = MODE_CSI;
        end else begin
          emit          = 1'b1;
          run_head.kind = KIND_ESC;
        end
      end
      MODE_CSI, MODE_CSIQ: begin
        run_head.kind = (mode == MODE_CSIQ) ? KIND_CSIQ : KIND_CSI;
        if (in_byte == BYTE_QMARK) begin
          if (mode == MODE_CSIQ || param_ptr != '0) begin
            emit              = 1'b1;
            run_head.is_error = 1'b1;
            run_count         = CW'(param_ptr);
          end else begin
            mode_next = MODE_CSIQ;
          end
        end else if (is_digit) begin
          param_store_next[param_ptr] =
            (digit_prod > 20'(VALUE_MAX)) ? VALUE_MAX : digit_prod[VALUE_W-1:0];
        end else if (in_byte == BYTE_SEMI) begin
          if (ptr_room) begin
            // The next slot is still zero since the last clear.
            param_ptr_next = param_ptr + PW'(1);
          end else begin
            emit              = 1'b1;
            run_head.is_error = 1'b1;
            run_count         = CW'(param_ptr);
          end
        end else begin
          emit      = 1'b1;
          run_count = cur_nonzero ? CW'(param_ptr) + CW'(1) : CW'(param_ptr);
        end
      end
      MODE_UTF8: begin
        glyph_acc_next = glyph_shift;
        cont_left_next = cont_dec;
        if (cont_dec == 3'd0) begin
          emit           = 1'b1;
          run_head.kind  = KIND_UTF8;
          run_head.glyph = glyph_shift;
        end
      end
      default: begin
        mode_next = MODE_RAW;
      end
    endcase
    // Drop all element state once a run is handed on.
    if (emit) begin
      mode_next      = MODE_RAW;
      glyph_acc_next = '0;
      cont_left_next = '0;
      param_ptr_next = '0;
      for (int i = 0; i < SLOTS; i++) begin
        param_store_next[i] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      run_params[i*VALUE_W +: VALUE_W] = param_store[i];
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RAW;
      glyph_acc <= '0;
      cont_left <= '0;
      param_ptr <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        param_store[i] <= '0;
      end
    end else if (accept) begin
      mode        <= mode_next;
      glyph_acc   <= glyph_acc_next;
      cont_left   <= cont_left_next;
      param_ptr   <= param_ptr_next;
      param_store <= param_store_next;
    end
  end

endmodule

[hdl/vusp_queue.sv]
// Short run-descriptor queue between the parser and the result serialiser.
// Depends on vusp_pkg.
module vusp_queue #(
  parameter int SLOTS = vusp_pkg::PARAM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  vusp_pkg::run_head_t                push_head,
  input  logic [$clog2(SLOTS+1)-1:0]         push_count,
  input  logic [SLOTS*vusp_pkg::VALUE_W-1:0] push_params,
  output logic                               push_ready,
  input  logic                               pop,
  output logic                               head_valid,
  output vusp_pkg::run_head_t                head,
  output logic [$clog2(SLOTS+1)-1:0]         head_count,
  output logic [SLOTS*vusp_pkg::VALUE_W-1:0] head_params
);
  import vusp_pkg::*;

  localparam int CW  = $clog2(SLOTS + 1);
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);

  run_head_t                  q_head   [QUEUE_DEPTH];
  logic [CW-1:0]              q_count  [QUEUE_DEPTH];
  logic [SLOTS*VALUE_W-1:0]   q_params [QUEUE_DEPTH];
  logic [QPW-1:0]             wr_ptr, rd_ptr;
  logic [FW-1:0]              fill;

  assign push_ready  = fill != FW'(QUEUE_DEPTH);
  assign head_valid  = fill != '0;
  assign head        = q_head[rd_ptr];
  assign head_count  = q_count[rd_ptr];
  assign head_params = q_params[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      q_head[wr_ptr]   <= push_head;
      q_count[wr_ptr]  <= push_count;
      q_params[wr_ptr] <= push_params;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      case ({push && push_ready, pop && head_valid})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/vusp_back.sv]
// Back part: walks the run at the queue head and presents one result per beat.
// Depends on vusp_pkg.
module vusp_back #(
  parameter int SLOTS = vusp_pkg::PARAM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  vusp_pkg::run_head_t                 head,
  input  logic [$clog2(SLOTS+1)-1:0]          head_count,
  input  logic [SLOTS*vusp_pkg::VALUE_W-1:0]  head_params,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [vusp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [vusp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);
  import vusp_pkg::*;

  localparam int PW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [PW-1:0]      idx;
  logic [CW-1:0]      run_len;
  logic               is_last;
  logic [VALUE_W-1:0] value;

  assign run_len = (head_count == '0) ? CW'(1) : head_count;
  assign is_last = (CW'(idx) + CW'(1)) == run_len;
  assign value   = (CW'(idx) < head_count) ? head_params[idx*VALUE_W +: VALUE_W] : '0;

  assign out_tvalid = head_valid;
  assign out_tlast  = is_last;
  assign out_tuser  = {head.is_error, head.kind};
  assign out_tdata  = {1'b0, value, 3'(idx), 4'(head_count), head.glyph, head.final_byte};
  assign pop        = out_tvalid && out_tready && is_last;

  // Advance through the run, rewind once its last beat goes out.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_tvalid && out_tready) begin
      idx <= is_last ? '0 : idx + PW'(1);
    end
  end

endmodule

[hdl/vt100_utf8_sequence_parser_unit.sv]
// Top level of the VT100/ANSI escape and UTF-8 input sequence parser.
// Depends on vusp_pkg, vusp_front, vusp_queue and vusp_back.
//
// Usage:
//   Input stream: one raw terminal byte per beat on in_tdata[7:0]. A beat
//   is taken when in_tvalid and in_tready are both high.
//   Output stream: each completed element (plain byte, escape pair, CSI
//   sequence, UTF-8 glyph) yields a run of results, one per CSI parameter
//   or a single result when there are none; out_tlast marks the final beat.
// Result path: a byte that completes an element writes its run into the
//   run queue as it is taken; the output shows the queue head's results.
// Throughput: one input byte per cycle. A run holds the output for
//   max(param_count, 1) beats; the two-entry run queue between the parser
//   and the serialiser sets how long the parser keeps going meanwhile, and
//   in_tready falls only while that queue is full.
// Reset: rst (synchronous, active high) returns the parser to the ground
//   state, clears all parameter slots and empties the run queue.
// Stall: while out_tready is low the current result holds steady; the
//   parser keeps taking bytes until the run queue is full.
module vt100_utf8_sequence_parser_unit #(
  parameter int PARAM_SLOTS = vusp_pkg::PARAM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: [7:0] in_byte
  input  logic [vusp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: [7:0] final_byte, [39:8] glyph, [43:40] param_count,
  //            [46:44] param_index, [62:47] param_value, [63] zero
  output logic [vusp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: [2:0] kind, [3] is_error
  output logic [vusp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);
  import vusp_pkg::*;

  localparam int CW = $clog2(PARAM_SLOTS + 1);

  logic                           accept;
  logic                           push;
  logic                           push_ready;
  run_head_t                      push_head;
  logic [CW-1:0]                  push_count;
  logic [PARAM_SLOTS*VALUE_W-1:0] push_params;
  logic                           pop;
  logic                           head_valid;
  run_head_t                      head;
  logic [CW-1:0]                  head_count;
  logic [PARAM_SLOTS*VALUE_W-1:0] head_params;

  // Hold input whenever the run queue is full.
  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  vusp_front #(.SLOTS(PARAM_SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_tdata[7:0]),
    .push       (push),
    .run_head   (push_head),
    .run_count  (push_count),
    .run_params (push_params)
  );

  vusp_queue #(.SLOTS(PARAM_SLOTS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_head   (push_head),
    .push_count  (push_count),
    .push_params (push_params),
    .push_ready  (push_ready),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head),
    .head_count  (head_count),
    .head_params (head_params)
  );

  vusp_back #(.SLOTS(PARAM_SLOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .head_count  (head_count),
    .head_params (head_params),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

[hdl/vusp_checker.sv]
// Port-level checker for the terminal sequence parser, bound to the top level.
// Depends on vusp_pkg and vt100_utf8_sequence_parser_unit_macros.svh.
`include "vt100_utf8_sequence_parser_unit_macros.svh"

module vusp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vusp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [vusp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import vusp_pkg::*;

  logic                           is_csi;
  logic                           no_glyph;
  logic                           stalled;
  logic                           one_beat;
  logic                           glyph_zero;
  logic                           err_ok;
  logic [OUT_DATA_W+OUT_USER_W:0] out_bus;

  assign is_csi     = (out_tuser[2:0] == KIND_CSI) || (out_tuser[2:0] == KIND_CSIQ);
  assign no_glyph   = is_csi || (out_tuser[2:0] == KIND_ESC);
  assign stalled    = out_tvalid && !out_tready;
  assign one_beat   = out_tlast && (out_tdata[46:44] == 3'd0);
  assign glyph_zero = out_tdata[39:8] == 32'd0;
  assign err_ok     = is_csi && (out_tdata[7:0] == BYTE_QMARK || out_tdata[7:0] == BYTE_SEMI);
  assign out_bus    = {out_tlast, out_tuser, out_tdata};

  // A stalled result beat holds.
  `VUSP_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_bus), "stalled beat changed")
  // Elements other than CSI always form a single-beat run.
  `VUSP_ASSERT_IMPLY(a_single_beat, out_tvalid && !is_csi, one_beat, "long non-CSI run")
  // Escape pairs and CSI sequences carry no glyph.
  `VUSP_ASSERT_IMPLY(a_glyph_zero, out_tvalid && no_glyph, glyph_zero, "glyph on escape or CSI")
  // Only a CSI sequence can end in error, and only on '?' or ';'.
  `VUSP_ASSERT_IMPLY(a_error_csi, out_tvalid && out_tuser[3], err_ok, "stray error flag")
  // Input is held back only while queued runs wait on the output.
  `VUSP_ASSERT_IMPLY(a_full_queue, !in_tready, out_tvalid, "input held with nothing queued")

endmodule

bind vt100_utf8_sequence_parser_unit vusp_checker u_vusp_checker (.*);

[dv/vt100_utf8_sequence_parser_unit_checker.sv]
// Checker for the terminal sequence parser: predicts result beats from the bytes taken in.
// Depends on vusp_pkg; instantiated beside the block by the testbench top.
module vt100_utf8_sequence_parser_unit_checker #(
  parameter int SLOTS = vusp_pkg::PARAM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vusp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vusp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [vusp_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending,
  output int                              beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import vusp_pkg::*;

  typedef enum logic [2:0] {PS_GROUND, PS_ESC, PS_CSI, PS_CSIQ, PS_UTF8} parse_state_t;

  typedef struct packed {
    run_head_t    head;
    logic [3:0]   param_count;
    logic [2:0]   param_index;
    logic [15:0]  param_value;
    logic         last;
  } result_beat_t;

  parse_state_t   ps = PS_GROUND;
  logic [31:0]    glyph_acc = '0;
  logic [2:0]     cont_left = '0;
  int             slot_ptr = 0;
  logic [15:0]    slots [SLOTS];
  result_beat_t   due_beats [$];
  int             fails = 0;
  int             beats = 0;

  initial begin
    foreach (slots[i]) slots[i] = '0;
  end

  task automatic clear_parser();
    ps        = PS_GROUND;
    glyph_acc = '0;
    cont_left = '0;
    slot_ptr  = 0;
    foreach (slots[i]) slots[i] = '0;
  endtask

  task automatic report(input string msg);
    fails++;
    $display("[%0t] beat %0d: %s", $time, beats, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] seen_v,
                             input logic [31:0] due_v);
    if (seen_v !== due_v)
      report($sformatf("%s got 0x%0h, expected 0x%0h", field, seen_v, due_v));
  endtask

  // Queue one beat per parameter (or a single beat), then back to ground.
  task automatic queue_run(input logic [2:0] kind, input logic err, input logic [7:0] fb,
                           input logic [31:0] gl, input int count);
    result_beat_t rb;
    int n;
    n = (count == 0) ? 1 : count;
    for (int k = 0; k < n; k++) begin
      rb.head.kind       = kind;
      rb.head.is_error   = err;
      rb.head.final_byte = fb;
      rb.head.glyph      = gl;
      rb.param_count     = count[3:0];
      rb.param_index     = k[2:0];
      rb.param_value     = (k < count && k < SLOTS) ? slots[k] : '0;
      rb.last            = (k + 1 == n);
      due_beats.push_back(rb);
    end
    clear_parser();
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int          p;
    int          acc;
    int          want;
    logic [7:0]  mask;
    logic [2:0]  csi_kind;
    p        = (slot_ptr < SLOTS) ? slot_ptr : SLOTS - 1;
    csi_kind = (ps == PS_CSIQ) ? KIND_CSIQ : KIND_CSI;
    case (ps)
      PS_ESC: begin
        if (b == BYTE_CSI) ps = PS_CSI;
        else queue_run(KIND_ESC, 1'b0, b, '0, 0);
      end
      PS_CSI, PS_CSIQ: begin
        if (b == BYTE_QMARK) begin
          // a second marker, or one after a separator, aborts the sequence
          if (ps == PS_CSIQ || p != 0) queue_run(csi_kind, 1'b1, b, '0, p);
          else ps = PS_CSIQ;
        end else if (b >= BYTE_DIG0 && b <= BYTE_DIG9) begin
          acc = int'(slots[p]) * 10 + int'(b - BYTE_DIG0);
          slots[p] = (acc > int'(VALUE_MAX)) ? VALUE_MAX : acc[15:0];
          slot_ptr = p;
        end else if (b == BYTE_SEMI) begin
          if (p + 1 < SLOTS) begin
            slot_ptr    = p + 1;
            slots[p+1]  = '0;
          end else begin
            queue_run(csi_kind, 1'b1, b, '0, p);
          end
        end else begin
          // an empty or zero last slot is not counted
          queue_run(csi_kind, 1'b0, b, '0, (slots[p] != 0) ? p + 1 : p);
        end
      end
      PS_UTF8: begin
        glyph_acc = {glyph_acc[25:0], b[5:0]};
        if (cont_left != 0) cont_left--;
        if (cont_left == 0) queue_run(KIND_UTF8, 1'b0, b, glyph_acc, 0);
      end
      default: begin
        if (b == BYTE_ESC) begin
          ps = PS_ESC;
        end else if (b[7]) begin
          mask = 8'h40;
          want = 0;
          while ((b & mask) != 0 && want < 5) begin
            want++;
            mask = mask >> 1;
          end
          cont_left = want[2:0];
          glyph_acc = {24'd0, b & (8'hff >> (want + 1))};
          ps        = PS_UTF8;
        end else begin
          queue_run(KIND_PLAIN, 1'b0, b, {24'd0, b}, 0);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_beat_t seen;
    result_beat_t due;
    if (rst) begin
      clear_parser();
      due_beats.delete();
    end else begin
      // compare first: a beat on the output never stems from a byte taken at the same edge
      if (out_tvalid && out_tready) begin
        beats++;
        seen.head.kind       = out_tuser[2:0];
        seen.head.is_error   = out_tuser[3];
        seen.head.final_byte = out_tdata[7:0];
        seen.head.glyph      = out_tdata[39:8];
        seen.param_count     = out_tdata[43:40];
        seen.param_index     = out_tdata[46:44];
        seen.param_value     = out_tdata[62:47];
        seen.last            = out_tlast;
        if (due_beats.size() == 0) begin
          report($sformatf("unexpected beat, tdata 0x%0h tuser 0x%0h", out_tdata, out_tuser));
        end else begin
          due = due_beats.pop_front();
          check_field("kind",        32'(seen.head.kind),       32'(due.head.kind));
          check_field("is_error",    32'(seen.head.is_error),   32'(due.head.is_error));
          check_field("final_byte",  32'(seen.head.final_byte), 32'(due.head.final_byte));
          check_field("glyph",       seen.head.glyph,           due.head.glyph);
          check_field("param_count", 32'(seen.param_count),     32'(due.param_count));
          check_field("param_index", 32'(seen.param_index),     32'(due.param_index));
          check_field("param_value", 32'(seen.param_value),     32'(due.param_value));
          check_field("last",        32'(seen.last),            32'(due.last));
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata[7:0]);
    end
    fail_count <= fails;
    pending    <= due_beats.size();
    beats_seen <= beats;
  end

endmodule

[dv/vt100_utf8_sequence_parser_unit_tb.sv]
// Testbench top for the terminal sequence parser: byte stimulus, output stalls, verdict.
// Depends on vusp_pkg, the parser RTL and vt100_utf8_sequence_parser_unit_checker.
module vt100_utf8_sequence_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vusp_pkg::*;

  localparam int RANDOM_BYTES = 60;
  // keep a wide margin over the slowest run
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  int fail_count;
  int pending;
  int beats_seen;

  int cycles     = 0;
  int bytes_fed  = 0;
  int rand_elems = 0;
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;

  vt100_utf8_sequence_parser_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  vt100_utf8_sequence_parser_unit_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .beats_seen (beats_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("** vt100_utf8_sequence_parser_unit: FAILED **");
      $finish;
    end
  end

  // Offer one byte: idle for a drawn number of cycles, then hold the beat until taken.
  // With no gap, valid stays high and only the data changes.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk) begin
      in_tvalid <= 1'b1;
      in_tdata  <= b;
    end
    do @(posedge clk); while (!in_tready);
    bytes_fed++;
  endtask

  // ESC '[' followed by the given body
  task automatic send_csi(input string body);
    send_byte(BYTE_ESC);
    send_byte(BYTE_CSI);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
  endtask

  // Stop feeding and let every predicted result drain out, then hold off briefly.
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pick a byte that ends a CSI sequence: anything but a digit, ';' or '?'.
  function automatic logic [7:0] pick_final(input bit any_byte);
    logic [7:0] b;
    do begin
      b = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h40, 8'h7e));
    end while ((b >= BYTE_DIG0 && b <= BYTE_DIG9) || b == BYTE_SEMI || b == BYTE_QMARK);
    return b;
  endfunction

  task automatic random_element();
    int         n;
    int         ndig;
    int         want;
    logic [7:0] r;
    if ($urandom_range(0, 5) == 0) tx_idle = !tx_idle;
    rand_elems++;
    case ($urandom_range(0, 9))
      0, 1: send_byte(8'($urandom_range(0, 127)));
      2: begin
        send_byte(BYTE_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end
      3, 4, 5: begin
        // well-formed CSI: optional marker, a few parameters, one final byte
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        if ($urandom_range(0, 3) == 0) send_byte(BYTE_QMARK);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) send_byte(BYTE_SEMI);
          ndig = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 3);
          repeat (ndig) send_byte(BYTE_DIG0 + 8'($urandom_range(0, 9)));
        end
        send_byte(pick_final($urandom_range(0, 4) == 0));
      end
      6, 7: begin
        // glyph: lead with its ones run, then continuations, now and then a random byte
        want = $urandom_range(1, 5);
        r    = 8'($urandom_range(0, 255));
        send_byte(~(8'hff >> (want + 1)) | (r & (8'h7f >> (want + 1))));
        repeat (want) begin
          if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
          else send_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
      end
      8: begin
        // broken CSI: a jumble of digits, separators and markers
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        n = $urandom_range(1, 12);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0:       send_byte(BYTE_SEMI);
            1:       send_byte(BYTE_QMARK);
            default: send_byte(BYTE_DIG0 + 8'($urandom_range(0, 9)));
          endcase
        end
        send_byte(pick_final(1'b1));
      end
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Receiver: draw a stall per result beat, with stretches of none.
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      repeat (gap) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int directed_end;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // plain bytes at both ends of the range
    send_byte(8'h00);
    send_byte(8'h7f);
    // escape pairs, ESC after ESC among them
    send_byte(BYTE_ESC);
    send_byte(8'h41);
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    // CSI: no parameters, zero-only parameter, two parameters, private marker
    send_csi("m");
    send_csi("0m");
    send_csi("1;2H");
    send_csi("?25h");
    // saturation and a trailing empty slot
    send_csi("99999m");
    send_csi("5;m");
    // all slots in use, then one separator too many
    send_csi("1;2;3;4;5;6;7;8m");
    send_csi("1;2;3;4;5;6;7;8;");
    // repeated marker, late marker, late marker after a private one
    send_csi("??");
    send_csi("1;?");
    send_csi("?1;?");
    // two-, three- and four-byte glyphs
    send_byte(8'hc3); send_byte(8'ha9);
    send_byte(8'he2); send_byte(8'h82); send_byte(8'hac);
    send_byte(8'hf0); send_byte(8'h9f); send_byte(8'h98); send_byte(8'h80);
    // 0xFF lead: five continuations, filling all 32 glyph bits
    send_byte(8'hff);
    repeat (5) send_byte(8'hbf);
    // stray continuation swallows the next byte, ESC taken as a continuation
    send_byte(8'h85); send_byte(8'h41);
    send_byte(8'hc2); send_byte(BYTE_ESC);

    // let everything settle before the random part
    drain();
    directed_end = bytes_fed;

    while (bytes_fed < directed_end + RANDOM_BYTES) begin
      random_element();
      if (!drained_mid && bytes_fed >= directed_end + RANDOM_BYTES / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (16) @(posedge clk);

    $display("Fed %0d bytes: directed plain, escape, CSI, malformed CSI and glyph cases,",
             bytes_fed);
    $display("then %0d random elements; %0d result beats compared.", rand_elems, beats_seen);
    if (fail_count == 0) begin
      $display("** vt100_utf8_sequence_parser_unit: PASSED **");
    end else begin
      $display("** vt100_utf8_sequence_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/vusp_pkg.sv
hdl/vusp_front.sv
hdl/vusp_queue.sv
hdl/vusp_back.sv
hdl/vt100_utf8_sequence_parser_unit.sv
hdl/vusp_checker.sv
dv/vt100_utf8_sequence_parser_unit_checker.sv
dv/vt100_utf8_sequence_parser_unit_tb.sv
